FILE: hdl/ipat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipat_pkg
// Types, codes and limits shared by the IP address text parser and its
// stream interfaces.
// ----------------------------------------------------------------------------
package ipat_pkg;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FORMAT = 2'd1,
        ST_FAMILY = 2'd2
    } t_status;

    localparam logic [1:0] FAM_V4 = 2'd0;
    localparam logic [1:0] FAM_V6 = 2'd1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Character limits; the count register saturates at its all-ones value.
    localparam logic [5:0] MAX_V4_CHARS = 6'd16;
    localparam logic [5:0] MAX_V6_CHARS = 6'd40;
    localparam logic [5:0] CHAR_COUNT_SAT = 6'h3F;

    localparam logic [15:0] V4_GROUP_MAX = 16'h00FF;
    localparam logic [15:0] V6_GROUP_MAX = 16'hFFFF;
    localparam logic [15:0] V6_SHIFT_MAX = 16'h0FFF;
    localparam logic [2:0]  V4_DELIMS    = 3'd3;
    localparam logic [2:0]  V6_DELIMS    = 3'd7;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_digit;

    function automatic t_digit dec_digit(input logic [7:0] c);
        t_digit d;
        d.ok    = (c >= 8'h30) && (c <= 8'h39);
        d.value = 4'(c - 8'h30);
        return d;
    endfunction

    function automatic t_digit hex_digit(input logic [7:0] c);
        t_digit d;
        d.ok    = 1'b1;
        d.value = 4'd0;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            d.value = 4'(c - 8'h30);
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            d.value = 4'(c - 8'h57);
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            d.value = 4'(c - 8'h37);
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ipat_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipat_in_if / ipat_out_if
// Valid/ready stream interfaces for characters in and parse results out.
// ----------------------------------------------------------------------------
interface ipat_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] char_code;

    modport source (output valid, output func, output char_code, input ready);
    modport sink   (input valid, input func, input char_code, output ready);
endinterface

interface ipat_out_if;
    logic             valid;
    logic             ready;
    ipat_pkg::t_status status;
    logic [63:0]      address_upper;
    logic [63:0]      address_lower;

    modport source (output valid, output status, output address_upper,
                    output address_lower, input ready);
    modport sink   (input valid, input status, input address_upper,
                    input address_lower, output ready);
endinterface

`default_nettype wire

FILE: hdl/ip_address_text_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ip_address_text_parser
// Converts IPv4 dotted-decimal or IPv6 colon-hex text, one character per
// transaction, into a packed binary address.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle with no gaps of its own:
// every character updates the parse state in the cycle it is accepted, and
// a zero character loads the status and address into the output register,
// which drives the result channel from the next cycle, and clears the parse
// state for the next string. Input is stalled only while a result sits
// unclaimed in the output register. IPv6 text needs all eight groups written
// out. "::" is not expanded: an empty group reads as zero, so the string
// still needs exactly seven colons. Embedded dotted quads are reported as
// format errors. The address fields are zero for any status other than
// converted.
module ip_address_text_parser (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ipat_in_if.sink    i_in,
    ipat_out_if.source o_out
);
    import ipat_pkg::*;

    logic [15:0]  r_group_value, n_group_value;
    logic         r_group_ovf, n_group_ovf;
    logic [2:0]   r_delim_count, n_delim_count;
    logic [5:0]   r_char_count, n_char_count;
    logic         r_format_error, n_format_error;
    logic [127:0] r_addr, n_addr;

    logic         r_out_valid;
    t_status      r_status, n_status;
    logic [63:0]  r_addr_upper, n_addr_upper;
    logic [63:0]  r_addr_lower, n_addr_lower;

    logic         in_accept;
    logic         is_term;
    logic         is_v4;
    logic         is_v6;
    logic [5:0]   char_limit;
    logic [15:0]  group_max;
    logic [2:0]   delim_max;
    logic [7:0]   delim_char;
    logic         err_now;
    logic [19:0]  dec_next;
    t_digit       dec;
    t_digit       hex;

    assign in_accept = i_in.valid && i_in.ready;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign is_term = (i_in.char_code == CH_NUL);
    assign is_v4 = (i_in.func == FAM_V4);
    assign is_v6 = (i_in.func == FAM_V6);
    assign char_limit = is_v4 ? MAX_V4_CHARS : MAX_V6_CHARS;
    assign group_max = is_v4 ? V4_GROUP_MAX : V6_GROUP_MAX;
    assign delim_max = is_v4 ? V4_DELIMS : V6_DELIMS;
    assign delim_char = is_v4 ? CH_DOT : CH_COLON;
    assign dec = dec_digit(i_in.char_code);
    assign hex = hex_digit(i_in.char_code);
    // Times ten as two shifts and an add, plus the new digit.
    assign dec_next = ({4'b0, r_group_value} << 3) + ({4'b0, r_group_value} << 1)
                    + {16'b0, dec.value};

    // Parse-state update for a non-terminator character.
    always_comb begin
        n_group_value  = r_group_value;
        n_group_ovf    = r_group_ovf;
        n_delim_count  = r_delim_count;
        n_format_error = r_format_error;
        n_addr         = r_addr;
        n_char_count   = (r_char_count != CHAR_COUNT_SAT) ?
                         r_char_count + 6'd1 : r_char_count;
        err_now        = r_format_error || (r_char_count >= char_limit);
        if (is_v4 || is_v6) begin
            n_format_error = err_now;
            if (!err_now) begin
                if (is_v4 && dec.ok) begin
                    if (dec_next > 20'(V4_GROUP_MAX)) begin
                        n_group_ovf = 1'b1;
                    end else begin
                        n_group_value = dec_next[15:0];
                    end
                end else if (is_v6 && hex.ok) begin
                    if (r_group_value > V6_SHIFT_MAX) begin
                        n_group_ovf = 1'b1;
                    end else begin
                        n_group_value = {r_group_value[11:0], hex.value};
                    end
                end else if (i_in.char_code == delim_char) begin
                    if (r_group_ovf || (r_group_value > group_max) ||
                        (r_delim_count >= delim_max)) begin
                        n_format_error = 1'b1;
                    end else begin
                        n_addr = is_v4 ? {r_addr[119:0], r_group_value[7:0]}
                                       : {r_addr[111:0], r_group_value};
                        n_group_value = 16'd0;
                        n_delim_count = r_delim_count + 3'd1;
                    end
                end else begin
                    n_format_error = 1'b1;
                end
            end
        end
    end

    // Result for a terminator, closing the last group.
    always_comb begin
        n_status     = ST_OK;
        n_addr_upper = 64'd0;
        n_addr_lower = 64'd0;
        if (!(is_v4 || is_v6)) begin
            n_status = ST_FAMILY;
        end else if (r_format_error || r_group_ovf || (r_group_value > group_max) ||
                     (r_delim_count != delim_max)) begin
            n_status = ST_FORMAT;
        end else if (is_v4) begin
            n_addr_lower = {32'd0, r_addr[23:0], r_group_value[7:0]};
        end else begin
            n_addr_upper = r_addr[111:48];
            n_addr_lower = {r_addr[47:0], r_group_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_value  <= '0;
            r_group_ovf    <= 1'b0;
            r_delim_count  <= '0;
            r_char_count   <= '0;
            r_format_error <= 1'b0;
            r_addr         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_accept) begin
                if (is_term) begin
                    r_group_value  <= '0;
                    r_group_ovf    <= 1'b0;
                    r_delim_count  <= '0;
                    r_char_count   <= '0;
                    r_format_error <= 1'b0;
                    r_addr         <= '0;
                    r_out_valid    <= 1'b1;
                end else begin
                    r_group_value  <= n_group_value;
                    r_group_ovf    <= n_group_ovf;
                    r_delim_count  <= n_delim_count;
                    r_char_count   <= n_char_count;
                    r_format_error <= n_format_error;
                    r_addr         <= n_addr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && is_term) begin
            r_status     <= n_status;
            r_addr_upper <= n_addr_upper;
            r_addr_lower <= n_addr_lower;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.address_upper = r_addr_upper;
    assign o_out.address_lower = r_addr_lower;

`ifndef SYNTHESIS
    a_err_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != ST_OK)) |->
        ((r_addr_upper == 64'd0) && (r_addr_lower == 64'd0)))
        else $error("address not zero on a failed conversion");

    a_term_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && is_term) |=> (r_out_valid && (r_char_count == 6'd0) &&
        !r_format_error && (r_delim_count == 3'd0)))
        else $error("terminator did not give a result and clear the state");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !is_term && o_out.ready) |=> !r_out_valid)
        else $error("result produced by a non-terminator character");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_format_error && !(in_accept && is_term)) |=> r_format_error)
        else $error("format error cleared before the terminator");
`endif

endmodule

`default_nettype wire

FILE: test/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IP address text parser. Directed strings cover
// the edge cases of both address families. Random dotted-decimal and
// colon-hex strings follow, most well formed and some deliberately broken.
// A scoreboard predicts each result from the characters the block accepts
// and checks it against the result channel. Both handshakes are throttled
// at random, except in the last random phase.
// ----------------------------------------------------------------------------
module tb;
    import ipat_pkg::*;

    localparam int RANDOM_CHARS_PER_PHASE = 225;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        t_status     status;
        logic [63:0] upper;
        logic [63:0] lower;
    } t_parse_result;

    class address_scoreboard;
        logic [15:0]   group_acc;
        bit            group_ovf;
        logic [2:0]    delim_cnt;
        logic [5:0]    char_cnt;
        bit            fmt_err;
        logic [127:0]  addr_shift;
        t_parse_result expected_addrs[$];
        int            failures;

        function new();
            failures = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            group_acc  = '0;
            group_ovf  = 1'b0;
            delim_cnt  = '0;
            char_cnt   = '0;
            fmt_err    = 1'b0;
            addr_shift = '0;
        endfunction

        function void shift_group(bit v4);
            if (v4) begin
                addr_shift = {addr_shift[119:0], group_acc[7:0]};
            end else begin
                addr_shift = {addr_shift[111:0], group_acc};
            end
        endfunction

        function void decode_digit(bit v4, logic [7:0] c, output bit ok,
                                   output logic [3:0] value);
            ok    = 1'b1;
            value = 4'(c - "0");
            if (c >= "0" && c <= "9") begin
                value = 4'(c - "0");
            end else if (!v4 && c >= "a" && c <= "f") begin
                value = 4'(c - "a" + 8'd10);
            end else if (!v4 && c >= "A" && c <= "F") begin
                value = 4'(c - "A" + 8'd10);
            end else begin
                ok = 1'b0;
            end
        endfunction

        function void note_char(logic [1:0] fam, logic [7:0] c);
            t_parse_result r;
            bit            v4;
            bit            is_digit;
            logic [3:0]    digit;
            logic [5:0]    limit;
            logic [15:0]   gmax;
            logic [2:0]    dmax;
            int unsigned   n;

            v4    = (fam == FAM_V4);
            limit = v4 ? MAX_V4_CHARS : MAX_V6_CHARS;
            gmax  = v4 ? V4_GROUP_MAX : V6_GROUP_MAX;
            dmax  = v4 ? V4_DELIMS : V6_DELIMS;

            if (c != CH_NUL) begin
                if (fam != FAM_V4 && fam != FAM_V6) begin
                    if (char_cnt != CHAR_COUNT_SAT) char_cnt++;
                    return;
                end
                if (char_cnt >= limit) fmt_err = 1'b1;
                if (char_cnt != CHAR_COUNT_SAT) char_cnt++;
                if (fmt_err) return;
                decode_digit(v4, c, is_digit, digit);
                if (is_digit) begin
                    if (v4) begin
                        n = group_acc;
                        n = n * 10 + digit;
                        if (n > V4_GROUP_MAX) group_ovf = 1'b1;
                        else group_acc = 16'(n);
                    end else begin
                        if (group_acc > V6_SHIFT_MAX) group_ovf = 1'b1;
                        else group_acc = {group_acc[11:0], digit};
                    end
                end else if (c == (v4 ? CH_DOT : CH_COLON)) begin
                    if (group_ovf || group_acc > gmax || delim_cnt >= dmax) begin
                        fmt_err = 1'b1;
                        return;
                    end
                    shift_group(v4);
                    group_acc = '0;
                    delim_cnt++;
                end else begin
                    fmt_err = 1'b1;
                end
                return;
            end

            // The terminator closes the string and always yields one result.
            r.upper = '0;
            r.lower = '0;
            if (fam != FAM_V4 && fam != FAM_V6) begin
                r.status = ST_FAMILY;
            end else if (fmt_err || group_ovf || group_acc > gmax || delim_cnt != dmax) begin
                r.status = ST_FORMAT;
            end else begin
                shift_group(v4);
                r.status = ST_OK;
                if (v4) r.lower = {32'd0, addr_shift[31:0]};
                else {r.upper, r.lower} = addr_shift;
            end
            expected_addrs.push_back(r);
            clear_parse();
        endfunction

        function void check_result(t_status st, logic [63:0] up, logic [63:0] lo);
            t_parse_result e;
            if (expected_addrs.size() == 0) begin
                if (failures < 10) begin
                    $display("unexpected result: status %0d upper %h lower %h",
                             st, up, lo);
                end
                failures++;
                return;
            end
            e = expected_addrs.pop_front();
            if (st !== e.status || up !== e.upper || lo !== e.lower) begin
                if (failures < 10) begin
                    $display("result mismatch: expected status %0d upper %h lower %h",
                             e.status, e.upper, e.lower);
                    $display("                 actual   status %0d upper %h lower %h",
                             st, up, lo);
                end
                failures++;
            end
        endfunction

        function int outstanding();
            return expected_addrs.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ipat_in_if  in_ch ();
    ipat_out_if out_ch ();

    ip_address_text_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    address_scoreboard sb = new();
    int tx_idle_pct = 34;
    int rx_idle_pct = 47;
    int chars_sent  = 0;
    int idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result channel back-pressure.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
            sb.note_char(in_ch.func, in_ch.char_code);
        end
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            sb.check_result(out_ch.status, out_ch.address_upper, out_ch.address_lower);
        end
    end

    // Watchdog: counts cycles in which neither channel completes a transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Called just after a rising edge; returns at the edge that accepts the
    // character.
    task automatic put_char(logic [1:0] fam, logic [7:0] c);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.func      <= fam;
        in_ch.char_code <= c;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        chars_sent++;
    endtask

    // Sends a string and its terminator. With stray_pct set, some characters
    // carry a random family instead of the string's own.
    task automatic send_text(string s, logic [1:0] fam, logic [1:0] end_fam,
                             int stray_pct = 0);
        logic [1:0] f;
        for (int i = 0; i < s.len(); i++) begin
            f = ($urandom_range(0, 99) < stray_pct) ? 2'($urandom_range(0, 3)) : fam;
            put_char(f, s[i]);
        end
        put_char(end_fam, CH_NUL);
    endtask

    function automatic string v4_text();
        string s;
        int    octet;
        s = "";
        for (int i = 0; i < 4; i++) begin
            octet = $urandom_range(0, 3) == 0 ? $urandom_range(0, 9) : $urandom_range(0, 255);
            if (i != 0) s = {s, "."};
            s = {s, $urandom_range(0, 3) == 0 ? $sformatf("%03d", octet)
                                              : $sformatf("%0d", octet)};
        end
        return s;
    endfunction

    function automatic string v6_text();
        string       s;
        string       g;
        logic [15:0] value;
        s = "";
        for (int i = 0; i < 8; i++) begin
            value = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 15)) : 16'($urandom);
            g = $urandom_range(0, 1) ? $sformatf("%0h", value) : $sformatf("%04h", value);
            if ($urandom_range(0, 1)) g = g.toupper();
            if (i != 0) s = {s, ":"};
            s = {s, g};
        end
        return s;
    endfunction

    task automatic send_random_address();
        string      s;
        logic [1:0] fam;
        logic [1:0] end_fam;
        int         stray;
        int         p;
        int         pick;

        pick = $urandom_range(0, 99);
        fam  = (pick < 5) ? 2'($urandom_range(2, 3)) : (pick < 52) ? FAM_V4 : FAM_V6;
        s    = ($urandom_range(0, 1) || fam == FAM_V4) ? v4_text() : v6_text();
        if (fam == FAM_V6) s = v6_text();
        end_fam = fam;
        stray   = 0;

        // About a quarter of the strings get broken in one way or another.
        if ($urandom_range(0, 99) < 28) begin
            p = $urandom_range(0, s.len());
            case ($urandom_range(0, 7))
                0: s = {s.substr(0, p - 1), $sformatf("%c", 8'($urandom_range(1, 255))),
                        s.substr(p, s.len() - 1)};
                1: if (p < s.len()) s = {s.substr(0, p - 1), s.substr(p + 1, s.len() - 1)};
                2: s = {s, (fam == FAM_V4) ? ".7" : ":7"};
                3: s = {(fam == FAM_V4) ? "3" : "F", s};
                4: end_fam = 2'($urandom_range(0, 3));
                5: stray = 20;
                6: s = {s, s};
                default: s = {s.substr(0, p - 1), (fam == FAM_V4) ? "." : ":",
                              s.substr(p, s.len() - 1)};
            endcase
        end
        send_text(s, fam, end_fam, stray);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.func      <= FAM_V4;
        in_ch.char_code <= CH_NUL;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("0.0.0.0", FAM_V4, FAM_V4);
        send_text("255.255.255.255", FAM_V4, FAM_V4);
        send_text("256.1.1.1", FAM_V4, FAM_V4);
        send_text("1.2.3.256", FAM_V4, FAM_V4);
        send_text("1.2.3", FAM_V4, FAM_V4);
        send_text("1.2.3.4.5", FAM_V4, FAM_V4);
        send_text("1..3.", FAM_V4, FAM_V4);
        send_text("1.2.3.x", FAM_V4, FAM_V4);
        send_text("001.002.003.0004", FAM_V4, FAM_V4);
        send_text("001.002.003.00004", FAM_V4, FAM_V4);
        send_text("", FAM_V4, FAM_V4);
        send_text("0:0:0:0:0:0:0:0", FAM_V6, FAM_V6);
        send_text("ffff:FFFF:abcd:ABCD:1234:5678:9a0b:c0De", FAM_V6, FAM_V6);
        send_text("12345:0:0:0:0:0:0:0", FAM_V6, FAM_V6);
        send_text("1::2", FAM_V6, FAM_V6);
        send_text("1:2:3:4:5:6:7:8:9", FAM_V6, FAM_V6);
        send_text("1:2:3:4:5:6:7:1.2.3.4", FAM_V6, FAM_V6);
        send_text("0000:0000:0000:0000:0000:0000:0000:00000", FAM_V6, FAM_V6);
        send_text("0000:0000:0000:0000:0000:0000:0000:000000", FAM_V6, FAM_V6);
        send_text("g:0:0:0:0:0:0:0", FAM_V6, FAM_V6);
        send_text("1.2.3.4", 2'd2, 2'd2);
        send_text("1:2:3:4:5:6:7:8", 2'd3, 2'd3);
        send_text("1.2.3.4", FAM_V4, FAM_V6);
        send_text("\xff\x80", FAM_V4, FAM_V4);

        for (int phase = 0; phase < 3; phase++) begin
            int stop_at;
            stop_at = chars_sent + RANDOM_CHARS_PER_PHASE;
            tx_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 47 : 0;
            rx_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 34 : 0;
            while (chars_sent < stop_at) send_random_address();
        end
        in_ch.valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

`default_nettype wire
